// File: src/swm_pkg.sv
// Package for the sliding window minimum core.
// Holds field widths, parameter defaults and the shift control struct.
// No dependencies.
package swm_pkg;

  localparam int unsigned SampleW        = 31;
  localparam int unsigned CfgW           = 7;
  localparam int unsigned MaxWindowDef   = 64;
  localparam logic [CfgW-1:0] CfgResetVal = CfgW'(1);

  typedef struct packed {
    logic en;
    logic first;
  } swm_shift_t;

endpackage

// File: src/swm_cell.sv
// One cell of the prefix-minimum chain.
// Holds the minimum of the newest samples up to its own depth; uses swm_pkg.
module swm_cell
  import swm_pkg::*;
(
  input  logic               clk_i,
  input  swm_shift_t         shift_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic [SampleW-1:0] prev_min_i,
  output logic [SampleW-1:0] min_o
);

  logic [SampleW-1:0] min_q;
  logic [SampleW-1:0] min_d;

  always_comb begin
    if (shift_i.first || (sample_i < prev_min_i)) begin
      min_d = sample_i;
    end else begin
      min_d = prev_min_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i.en) begin
      min_q <= min_d;
    end
  end

  assign min_o = min_q;

endmodule

// File: src/sliding_window_minimum_core.sv
// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_stall_o    sample_value_i, first_of_sequence_i
// output    out        out_valid_o / out_stall_i  window_min_o
// config    in         window_length_we_i         window_length_i
//
// One beat is accepted per cycle unless stalled; each full window's result is registered.
// Every cell of the chain updates its prefix minimum in parallel, so the chain sets no limit.
// Input stalls only while a result sits in the output register and the output is stalled.
// Reset clears the fill count, the output valid and sets the window length to one.
// Top level of the sliding window minimum core; uses swm_pkg and swm_cell.
module sliding_window_minimum_core
  import swm_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = MaxWindowDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [SampleW-1:0] sample_value_i,
  input  logic               first_of_sequence_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SampleW-1:0] window_min_o,
  input  logic               window_length_we_i,
  input  logic [CfgW-1:0]    window_length_i
);

  localparam int unsigned LenW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CmpW = (LenW > CfgW) ? LenW : CfgW;
  localparam int unsigned IdxW = $clog2(MAX_WINDOW);

  logic [CfgW-1:0]    window_length_q;
  logic [LenW-1:0]    fill_q;
  logic [LenW-1:0]    fill_d;
  logic               out_valid_q;
  logic [SampleW-1:0] out_min_q;

  logic [CmpW-1:0]    len_wide;
  logic [LenW-1:0]    eff_len;
  logic [LenW-1:0]    fill_inc;
  logic               in_acc;
  logic               result_now;
  logic [IdxW-1:0]    sel;
  logic [SampleW-1:0] tap_min;
  logic [SampleW-1:0] result_min;
  swm_shift_t         shift;

  logic [SampleW-1:0] cell_min [MAX_WINDOW];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    len_wide = CmpW'(window_length_q);
    if (len_wide == '0) begin
      eff_len = LenW'(1);
    end else if (len_wide > CmpW'(MAX_WINDOW)) begin
      eff_len = LenW'(MAX_WINDOW);
    end else begin
      eff_len = LenW'(len_wide);
    end
  end

  always_comb begin
    fill_inc   = (first_of_sequence_i ? '0 : fill_q) + LenW'(1);
    result_now = (fill_inc >= eff_len);
    fill_d     = fill_q;
    if (in_acc) begin
      fill_d = result_now ? (eff_len - LenW'(1)) : fill_inc;
    end
  end

  assign shift.en    = in_acc;
  assign shift.first = first_of_sequence_i;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    swm_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (shift),
      .sample_i   (sample_value_i),
      .prev_min_i ((i == 0) ? sample_value_i : cell_min[(i == 0) ? 0 : i - 1]),
      .min_o      (cell_min[i])
    );
  end

  assign sel     = IdxW'(eff_len - LenW'(2));
  assign tap_min = cell_min[sel];

  always_comb begin
    if (eff_len == LenW'(1) || sample_value_i < tap_min) begin
      result_min = sample_value_i;
    end else begin
      result_min = tap_min;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= CfgResetVal;
      fill_q          <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (window_length_we_i) begin
        window_length_q <= window_length_i;
      end
      fill_q <= fill_d;
      if (in_acc && result_now) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && result_now) begin
      out_min_q <= result_min;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign window_min_o = out_min_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < LenW'(MAX_WINDOW))
    else $error("fill count reached the chain length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && result_now |=> out_valid_q)
    else $error("accepted beat with a result left the output empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && first_of_sequence_i && eff_len != LenW'(1) |=> fill_q == LenW'(1))
    else $error("new sequence did not restart the fill count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !result_now |=> fill_q == $past(fill_inc))
    else $error("fill count did not advance on a beat without result");

endmodule

// File: verif/tb.sv
// Self-checking testbench for sliding_window_minimum_core: a directed sequence, then
// random window lengths and sample streams with random idling on both channels.
// Depends on swm_pkg and the core RTL.
`timescale 1ns / 100ps

module tb;
  import swm_pkg::*;

  localparam int unsigned MaxWin = MaxWindowDef;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned RandomBeats = 1300;

  typedef struct {
    logic [SampleW-1:0] value;
    logic               first;
  } sample_beat_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [SampleW-1:0] sample_value_i = '0;
  logic               first_of_sequence_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [SampleW-1:0] window_min_o;
  logic               window_length_we_i = 1'b0;
  logic [CfgW-1:0]    window_length_i = CfgResetVal;

  sample_beat_t       pending_beats[$];
  logic [SampleW-1:0] min_expected[$];

  logic [SampleW-1:0] win_store[MaxWin];
  int unsigned        win_held;
  int unsigned        win_head;
  logic [CfgW-1:0]    win_len_reg;

  logic               in_taken = 1'b0;
  logic               out_taken = 1'b0;
  int unsigned        mismatch_count = 0;
  int unsigned        idle_cycles = 0;
  int unsigned        long_hold_req = 0;
  int unsigned        long_hold_done = 0;

  int unsigned        send_wait = 0;
  bit                 tx_quiet = 1'b0;
  int unsigned        rx_wait = 0;
  bit                 rx_quiet = 1'b0;

  sliding_window_minimum_core #(
    .MAX_WINDOW(MaxWin)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .sample_value_i     (sample_value_i),
    .first_of_sequence_i(first_of_sequence_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .window_min_o       (window_min_o),
    .window_length_we_i (window_length_we_i),
    .window_length_i    (window_length_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned effective_length(input logic [CfgW-1:0] len);
    if (len == 0) return 1;
    if (len > MaxWin) return MaxWin;
    return len;
  endfunction

  function automatic bit next_window_min(input logic [SampleW-1:0] value, input logic first,
                                         output logic [SampleW-1:0] least);
    int unsigned eff;
    logic [SampleW-1:0] best;
    eff = effective_length(win_len_reg);
    if (first) begin
      win_held = 0;
      win_head = 0;
    end
    if (win_held >= MaxWin) win_held = MaxWin - 1;
    win_store[(win_head + win_held) % MaxWin] = value;
    win_held++;
    if (win_held > eff) begin
      win_head = (win_head + win_held - eff) % MaxWin;
      win_held = eff;
    end
    if (win_held < eff) return 1'b0;
    best = win_store[win_head];
    for (int unsigned i = 1; i < eff; i++) begin
      if (win_store[(win_head + i) % MaxWin] < best) best = win_store[(win_head + i) % MaxWin];
    end
    win_head = (win_head + 1) % MaxWin;
    win_held--;
    least = best;
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    logic [SampleW-1:0] least;
    if (!rst_ni) begin
      win_held = 0;
      win_head = 0;
      win_len_reg = CfgResetVal;
      in_taken <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && !in_stall_o;
      out_taken <= out_valid_o && !out_stall_i;
      if (window_length_we_i) win_len_reg = window_length_i;
      if (out_valid_o && !out_stall_i) begin
        if (min_expected.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual window_min %0d",
                   $time, window_min_o);
          mismatch_count++;
        end else begin
          least = min_expected.pop_front();
          if (window_min_o !== least) begin
            $display("%0t: window_min mismatch, expected %0d, actual %0d",
                     $time, least, window_min_o);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        if (next_window_min(sample_value_i, first_of_sequence_i, least)) begin
          min_expected.push_back(least);
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("** sliding_window_minimum_core: FAILED **");
          $finish;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    sample_beat_t beat;
    if (in_valid_i && !in_taken) begin
    end else if (send_wait > 0) begin
      send_wait--;
      in_valid_i <= 1'b0;
    end else if (rst_ni && pending_beats.size() != 0) begin
      beat = pending_beats.pop_front();
      sample_value_i <= beat.value;
      first_of_sequence_i <= beat.first;
      in_valid_i <= 1'b1;
      if ($urandom_range(0, 40) == 0) tx_quiet = !tx_quiet;
      send_wait = tx_quiet ? 0 : $urandom_range(0, 6);
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (long_hold_req != long_hold_done) begin
      long_hold_done++;
      rx_wait = 250;
    end else if (out_taken) begin
      if ($urandom_range(0, 40) == 0) rx_quiet = !rx_quiet;
      rx_wait = rx_quiet ? 0 : $urandom_range(0, 6);
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_stall_i <= (rx_wait > 0);
  end

  task automatic push_sample(input logic [SampleW-1:0] value, input logic first);
    sample_beat_t beat;
    beat.value = value;
    beat.first = first;
    pending_beats.push_back(beat);
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_valid_i || min_expected.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [CfgW-1:0] len);
    @(negedge clk_i);
    window_length_we_i <= 1'b1;
    window_length_i <= len;
    @(negedge clk_i);
    window_length_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [SampleW-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return {SampleW{1'b1}};
      2, 3: return SampleW'($urandom_range(0, 15));
      default: return SampleW'($urandom());
    endcase
  endfunction

  initial begin
    int unsigned total;
    int unsigned phase;
    int unsigned eff;
    int unsigned count;
    logic [CfgW-1:0] len;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_sample('0, 1'b1);
    push_sample({SampleW{1'b1}}, 1'b0);
    push_sample(31'h2AAA_AAAA, 1'b0);
    push_sample(31'h5555_5555, 1'b1);
    wait_drained();
    write_length('0);
    push_sample(31'd1234, 1'b0);
    push_sample('0, 1'b0);
    wait_drained();
    write_length(CfgW'(3));
    push_sample(31'd10, 1'b1);
    push_sample(31'd5, 1'b0);
    push_sample(31'd20, 1'b0);
    push_sample(31'd30, 1'b0);
    push_sample(31'd1, 1'b0);
    push_sample({SampleW{1'b1}}, 1'b0);
    wait_drained();
    write_length(CfgW'(2));
    push_sample(31'd9, 1'b0);
    push_sample(31'd9, 1'b0);
    wait_drained();
    write_length(CfgW'(5));
    push_sample(31'd4, 1'b0);
    push_sample(31'd3, 1'b0);
    push_sample(31'd8, 1'b0);
    push_sample(31'd6, 1'b0);

    total = 0;
    phase = 0;
    while (total < RandomBeats) begin
      wait_drained();
      case (phase)
        0: len = CfgW'(MaxWin);
        1: len = {CfgW{1'b1}};
        2: len = '0;
        3: len = CfgW'(2);
        4: len = CfgW'(MaxWin + 1);
        default: begin
          case ($urandom_range(0, 9))
            0: len = CfgW'($urandom_range(MaxWin, (1 << CfgW) - 1));
            1, 2: len = CfgW'($urandom_range(9, MaxWin - 1));
            default: len = CfgW'($urandom_range(1, 8));
          endcase
        end
      endcase
      write_length(len);
      eff = effective_length(len);
      if (phase == 3) long_hold_req++;
      count = eff + $urandom_range(20, 60);
      for (int unsigned k = 0; k < count; k++) begin
        push_sample(random_sample(),
                    (k == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, eff + 40) == 0);
      end
      total += count;
      phase++;
    end
    wait_drained();

    if (mismatch_count == 0) begin
      $display("** sliding_window_minimum_core: PASSED **");
    end else begin
      $display("** sliding_window_minimum_core: FAILED **");
    end
    $finish;
  end

endmodule
